>>> design/gradient_noise_2d_macros.svh
// Assertion macros for the checker file gn2_checker.sv.
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define GN2_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define GN2_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/gn2_pkg.sv
// Package: shared types and constants of the 2D gradient noise block.
`default_nettype none
package gn2_pkg;

  localparam int POS_W    = 24;
  localparam int G_W      = 16;
  localparam int CFG_W    = 7;
  localparam int TABLE_AW = 12;
  localparam int Q14_ONE  = 16384;

  // fade: inner = (10*2^32 - t*(15*2^16 - 6t)) >> 16
  localparam logic [19:0] FADE_B = 20'd983040;
  localparam logic [35:0] FADE_A = 36'hA_0000_0000;

  typedef struct packed {
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
  } grad_t;

  function automatic logic signed [G_W-1:0] sat_q14(input logic signed [G_W-1:0] v);
    logic signed [G_W-1:0] r;
    r = v;
    if (v > $signed(G_W'(Q14_ONE))) r = $signed(G_W'(Q14_ONE));
    if (v < -$signed(G_W'(Q14_ONE))) r = -$signed(G_W'(Q14_ONE));
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/gn2_item_if.sv
// Interface: input word channel of the noise block.
`default_nettype none
interface gn2_item_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [gn2_pkg::POS_W-1:0]          pos_x;
  logic [gn2_pkg::POS_W-1:0]          pos_y;
  logic [gn2_pkg::TABLE_AW-1:0]       entry_index;
  logic signed [gn2_pkg::G_W-1:0]     entry_gx;
  logic signed [gn2_pkg::G_W-1:0]     entry_gy;

  modport source (output valid, mode, pos_x, pos_y, entry_index, entry_gx, entry_gy,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, entry_index, entry_gx, entry_gy,
                output ready);
endinterface
`default_nettype wire

>>> design/gn2_result_if.sv
// Interface: output word channel of the noise block.
`default_nettype none
interface gn2_result_if;
  logic                           valid;
  logic                           ready;
  logic signed [gn2_pkg::G_W-1:0] noise;

  modport source (output valid, noise, input ready);
  modport sink (input valid, noise, output ready);
endinterface
`default_nettype wire

>>> design/gradient_noise_2d.sv
// 2D gradient noise with quintic fade, fully pipelined.
// Channels: item (sink) carries load words (mode 0) that write one gradient
// entry, and evaluate words (mode 1) with a Q.8 position. result (source)
// carries one Q1.14 noise word per evaluate word; load words produce none.
// cfg_we/cfg_wdata write grid_width; write it only while the pipe is empty.
// Throughput: one word per cycle while result is not stalled. The pipe is the
// input register, MOD_ST = ceil((24 - FRAC_BITS)/4) modulo stages, then
// stages A to H. The corner wrap is a radix-16 remainder pipe, 4 bits a stage.
// Gradients live in two mirrored 4096-entry memories, two reads each, all
// written by a load word at the read stage so word order is kept.
// Reset clears valid bits and sets grid_width to 64; the gradient memories
// are not cleared and must be loaded before use.
// When result is stalled the whole pipe holds; item.ready drops only while
// a result word waits unaccepted.
`default_nettype none
module gradient_noise_2d #(
  parameter int MAX_GRID_WIDTH = 64,
  parameter int FRAC_BITS      = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  gn2_item_if.sink                         item,
  gn2_result_if.source                     result,
  input  wire logic                        cfg_we,
  input  wire logic [gn2_pkg::CFG_W-1:0]   cfg_wdata
);
  import gn2_pkg::*;

  localparam int INT_W  = POS_W - FRAC_BITS;
  localparam int GW_W   = $clog2(MAX_GRID_WIDTH + 1);
  localparam int MOD_ST = (INT_W + 3) / 4;
  localparam int PADW   = MOD_ST * 4;
  localparam int OFS_W  = FRAC_BITS + 1;
  localparam int N_W    = FRAC_BITS + 18;
  localparam int P1_W   = N_W + 19;
  localparam int P2_W   = N_W + 20;
  localparam int V_W    = N_W + 2;
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  function automatic logic [GW_W-1:0] mod_step(input logic [GW_W-1:0] r_in,
                                               input logic [3:0] bits,
                                               input logic [GW_W-1:0] m);
    logic [GW_W:0]   t;
    logic [GW_W-1:0] r;
    r = r_in;
    for (int i = 3; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      r = t[GW_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [GW_W-1:0] wrap_inc(input logic [GW_W-1:0] c,
                                               input logic [GW_W-1:0] m);
    logic [GW_W:0] s;
    s = {1'b0, c} + 1'b1;
    return (s == {1'b0, m}) ? '0 : s[GW_W-1:0];
  endfunction

  function automatic logic signed [N_W-1:0] dot(input logic signed [OFS_W-1:0] dx,
                                                input logic signed [OFS_W-1:0] dy,
                                                input grad_t g);
    return N_W'(dx * g.gx) + N_W'(dy * g.gy);
  endfunction

  // configuration
  logic [CFG_W-1:0] grid_width;
  logic [GW_W-1:0]  gw;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= CFG_W'(64);
    end else if (cfg_we) begin
      grid_width <= cfg_wdata;
    end
  end

  always_comb begin
    if (grid_width < CFG_W'(2)) gw = GW_W'(2);
    else if (int'(grid_width) > MAX_GRID_WIDTH) gw = GW_W'(MAX_GRID_WIDTH);
    else gw = GW_W'(grid_width);
  end

  // pipeline control
  logic adv;
  logic h_vld, h_mode;
  logic signed [G_W-1:0] h_noise;

  assign adv          = !(h_vld && h_mode && !result.ready);
  assign item.ready   = adv;
  assign result.valid = h_vld && h_mode;
  assign result.noise = h_noise;

  // modulo stages; index 0 is the input register
  logic                 m_vld  [0:MOD_ST];
  logic                 m_mode [0:MOD_ST];
  logic [FRAC_BITS-1:0] m_fx   [0:MOD_ST];
  logic [FRAC_BITS-1:0] m_fy   [0:MOD_ST];
  logic [PADW-1:0]      m_qx   [0:MOD_ST];
  logic [PADW-1:0]      m_qy   [0:MOD_ST];
  logic [GW_W-1:0]      m_rx   [0:MOD_ST];
  logic [GW_W-1:0]      m_ry   [0:MOD_ST];
  logic [TABLE_AW-1:0]  m_idx  [0:MOD_ST];
  grad_t                m_g    [0:MOD_ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld[0] <= 1'b0;
    end else if (adv) begin
      m_vld[0] <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_mode[0] <= item.mode;
      m_fx[0]   <= item.pos_x[FRAC_BITS-1:0];
      m_fy[0]   <= item.pos_y[FRAC_BITS-1:0];
      m_qx[0]   <= PADW'(item.pos_x[POS_W-1:FRAC_BITS]);
      m_qy[0]   <= PADW'(item.pos_y[POS_W-1:FRAC_BITS]);
      m_rx[0]   <= '0;
      m_ry[0]   <= '0;
      m_idx[0]  <= item.entry_index;
      m_g[0].gx <= sat_q14(item.entry_gx);
      m_g[0].gy <= sat_q14(item.entry_gy);
    end
  end

  for (genvar k = 0; k < MOD_ST; k++) begin : g_mod
    always_ff @(posedge clk) begin
      if (rst) begin
        m_vld[k+1] <= 1'b0;
      end else if (adv) begin
        m_vld[k+1] <= m_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m_mode[k+1] <= m_mode[k];
        m_fx[k+1]   <= m_fx[k];
        m_fy[k+1]   <= m_fy[k];
        m_qx[k+1]   <= m_qx[k] << 4;
        m_qy[k+1]   <= m_qy[k] << 4;
        m_rx[k+1]   <= mod_step(m_rx[k], m_qx[k][PADW-1 -: 4], gw);
        m_ry[k+1]   <= mod_step(m_ry[k], m_qy[k][PADW-1 -: 4], gw);
        m_idx[k+1]  <= m_idx[k];
        m_g[k+1]    <= m_g[k];
      end
    end
  end

  // stage A: neighbor corners, row offsets, fade step 1
  logic                 a_vld, a_mode;
  logic [FRAC_BITS-1:0] a_fx, a_fy;
  logic [GW_W-1:0]      a_x0, a_x1;
  logic [2*GW_W-1:0]    a_y0w, a_y1w;
  logic [TABLE_AW-1:0]  a_idx;
  grad_t                a_g;
  logic [15:0]          a_tx, a_ty, a_t2x, a_t2y;
  logic [35:0]          a_px, a_py;
  logic [15:0]          tx, ty;
  logic [19:0]          cx, cy;
  logic [GW_W-1:0]      y1;

  always_comb begin
    tx = 16'(m_fx[MOD_ST]) << (16 - FRAC_BITS);
    ty = 16'(m_fy[MOD_ST]) << (16 - FRAC_BITS);
    cx = FADE_B - 20'(tx) * 20'd6;
    cy = FADE_B - 20'(ty) * 20'd6;
    y1 = wrap_inc(m_ry[MOD_ST], gw);
  end

  // stage B: addresses, fade step 2
  logic                 b_vld, b_mode;
  logic [FRAC_BITS-1:0] b_fx, b_fy;
  logic [TABLE_AW-1:0]  b_a00, b_a10, b_a01, b_a11, b_idx;
  grad_t                b_g;
  logic [19:0]          b_inx, b_iny;
  logic [15:0]          b_t3x, b_t3y;

  // stage C: gradients read, fade weights
  logic                 c_vld, c_mode;
  logic [FRAC_BITS-1:0] c_fx, c_fy;
  grad_t                c_g00, c_g10, c_g01, c_g11;
  logic [16:0]          c_wx, c_wy;

  // stage D: corner dot products
  logic                   d_vld, d_mode;
  logic signed [N_W-1:0]  d_n00, d_n10, d_n01, d_n11;
  logic [16:0]            d_wx, d_wy;
  logic signed [OFS_W-1:0] dx0, dx1, dy0, dy1;

  always_comb begin
    dx0 = $signed({1'b0, c_fx});
    dy0 = $signed({1'b0, c_fy});
    dx1 = $signed(OFS_W'({1'b0, c_fx}) - OFS_W'(ONE));
    dy1 = $signed(OFS_W'({1'b0, c_fy}) - OFS_W'(ONE));
  end

  // stage E: x blend products
  logic                   e_vld, e_mode;
  logic signed [N_W-1:0]  e_n00, e_n01;
  logic signed [P1_W-1:0] e_p0, e_p1;
  logic [16:0]            e_wy;

  // stage F: x blend sums
  logic                   f_vld, f_mode;
  logic signed [N_W:0]    f_a, f_b;
  logic [16:0]            f_wy;

  // stage G: y blend product
  logic                   g_vld, g_mode;
  logic signed [N_W:0]    g_a;
  logic signed [P2_W-1:0] g_p;

  logic signed [V_W-1:0]  v, vr;
  logic signed [N_W:0]    diff2_lo;
  logic signed [N_W+1:0]  diff2;
  logic signed [N_W:0]    diff0, diff1;

  always_comb begin
    diff0    = (N_W+1)'(d_n10) - (N_W+1)'(d_n00);
    diff1    = (N_W+1)'(d_n11) - (N_W+1)'(d_n01);
    diff2_lo = '0;
    diff2    = (N_W+2)'(f_b) - (N_W+2)'(f_a);
    v        = V_W'(g_a) + V_W'(g_p >>> 16);
    vr       = (v + $signed(V_W'(HALF))) >>> FRAC_BITS;
  end

  // memories: two mirrored copies, two reads each
  grad_t mem0 [0:(1<<TABLE_AW)-1];
  grad_t mem1 [0:(1<<TABLE_AW)-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (b_vld && !b_mode) begin
        mem0[b_idx] <= b_g;
        mem1[b_idx] <= b_g;
      end
      c_g00 <= mem0[b_a00];
      c_g10 <= mem0[b_a10];
      c_g01 <= mem1[b_a01];
      c_g11 <= mem1[b_a11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= m_vld[MOD_ST];
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A
      a_mode <= m_mode[MOD_ST];
      a_fx   <= m_fx[MOD_ST];
      a_fy   <= m_fy[MOD_ST];
      a_x0   <= m_rx[MOD_ST];
      a_x1   <= wrap_inc(m_rx[MOD_ST], gw);
      a_y0w  <= (2*GW_W)'(m_ry[MOD_ST]) * (2*GW_W)'(gw);
      a_y1w  <= (2*GW_W)'(y1) * (2*GW_W)'(gw);
      a_idx  <= m_idx[MOD_ST];
      a_g    <= m_g[MOD_ST];
      a_tx   <= tx;
      a_ty   <= ty;
      a_px   <= 36'(tx) * 36'(cx);
      a_py   <= 36'(ty) * 36'(cy);
      a_t2x  <= 16'((32'(tx) * 32'(tx)) >> 16);
      a_t2y  <= 16'((32'(ty) * 32'(ty)) >> 16);
      // B
      b_mode <= a_mode;
      b_fx   <= a_fx;
      b_fy   <= a_fy;
      b_a00  <= TABLE_AW'((2*GW_W)'(a_x0) + a_y0w);
      b_a10  <= TABLE_AW'((2*GW_W)'(a_x1) + a_y0w);
      b_a01  <= TABLE_AW'((2*GW_W)'(a_x0) + a_y1w);
      b_a11  <= TABLE_AW'((2*GW_W)'(a_x1) + a_y1w);
      b_idx  <= a_idx;
      b_g    <= a_g;
      b_inx  <= 20'((FADE_A - a_px) >> 16);
      b_iny  <= 20'((FADE_A - a_py) >> 16);
      b_t3x  <= 16'((32'(a_t2x) * 32'(a_tx)) >> 16);
      b_t3y  <= 16'((32'(a_t2y) * 32'(a_ty)) >> 16);
      // C
      c_mode <= b_mode;
      c_fx   <= b_fx;
      c_fy   <= b_fy;
      c_wx   <= 17'((36'(b_t3x) * 36'(b_inx)) >> 16);
      c_wy   <= 17'((36'(b_t3y) * 36'(b_iny)) >> 16);
      // D
      d_mode <= c_mode;
      d_n00  <= dot(dx0, dy0, c_g00);
      d_n10  <= dot(dx1, dy0, c_g10);
      d_n01  <= dot(dx0, dy1, c_g01);
      d_n11  <= dot(dx1, dy1, c_g11);
      d_wx   <= c_wx;
      d_wy   <= c_wy;
      // E
      e_mode <= d_mode;
      e_n00  <= d_n00;
      e_n01  <= d_n01;
      e_p0   <= P1_W'(diff0 * $signed({1'b0, d_wx}));
      e_p1   <= P1_W'(diff1 * $signed({1'b0, d_wx}));
      e_wy   <= d_wy;
      // F
      f_mode <= e_mode;
      f_a    <= (N_W+1)'(e_n00) + (N_W+1)'(e_p0 >>> 16);
      f_b    <= (N_W+1)'(e_n01) + (N_W+1)'(e_p1 >>> 16);
      f_wy   <= e_wy;
      // G
      g_mode <= f_mode;
      g_a    <= f_a + diff2_lo;
      g_p    <= P2_W'(diff2 * $signed({1'b0, f_wy}));
      // H
      h_mode <= g_mode;
      if (vr > $signed(V_W'(Q14_ONE))) h_noise <= $signed(G_W'(Q14_ONE));
      else if (vr < -$signed(V_W'(Q14_ONE))) h_noise <= -$signed(G_W'(Q14_ONE));
      else h_noise <= G_W'(vr);
    end
  end

endmodule
`default_nettype wire

>>> design/gn2_checker.sv
// Checker: port-level assertions for the noise block, bound to the top level.
`default_nettype none
module gn2_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           item_valid,
  input wire logic                           item_ready,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic signed [gn2_pkg::G_W-1:0] noise
);
  import gn2_pkg::*;
  `include "gradient_noise_2d_macros.svh"

  `GN2_ASSERT(a_noise_range, clk, rst, result_valid |-> (noise <= $signed(G_W'(Q14_ONE)) && noise >= -$signed(G_W'(Q14_ONE))), "noise out of range")
  `GN2_ASSERT(a_stall_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(noise), "stalled word changed")
  `GN2_ASSERT(a_ready_free, clk, rst, !result_valid |-> item_ready, "input blocked with no word waiting")
  `GN2_ASSERT_NR(a_reset_empty, clk, rst |=> !result_valid, "word valid after reset")

endmodule

bind gradient_noise_2d gn2_checker u_gn2_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .noise        (result.noise)
);
`default_nettype wire
